@@ hdl/dtt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types, constants and codes for the detection track table.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int COORD_BITS_DEF  = 12;
  localparam int NUM_MASKS_DEF   = 3;
  localparam int MAX_RESULTS     = 16;
  localparam int FRAME_BITS      = 16;
  localparam int ID_BITS         = 16;
  localparam int MASK_BITS       = 3;
  localparam int HIT_BITS        = 8;
  localparam int VERDICT_BITS    = 3;
  localparam int RATIO_BITS      = 16;
  localparam int CNT_BITS        = 8;
  localparam logic [RATIO_BITS-1:0] FAR_MOVE = 16'd384;

  localparam logic [VERDICT_BITS-1:0] V_DEFINITE = 3'd0;
  localparam logic [VERDICT_BITS-1:0] V_POTENTIAL = 3'd1;
  localparam logic [VERDICT_BITS-1:0] V_ADDED = 3'd2;
  localparam logic [VERDICT_BITS-1:0] V_FULL = 3'd3;
  localparam logic [VERDICT_BITS-1:0] V_REPORT = 3'd4;
  localparam logic [VERDICT_BITS-1:0] V_NONE = 3'd5;

  localparam int REG_RECENT    = 0;
  localparam int REG_EXPIRE    = 1;
  localparam int REG_REAL      = 2;
  localparam int REG_NEAR_LOW  = 3;
  localparam int REG_NEAR_HIGH = 4;
  localparam int REG_NEAR_MOVE = 5;
  localparam int REG_FAR_LOW   = 6;
  localparam int REG_FAR_HIGH  = 7;
  localparam int NUM_REGS      = 8;
  localparam int ADDR_BITS     = 5;

  typedef struct packed {
    logic [CNT_BITS-1:0]   recent;
    logic [CNT_BITS-1:0]   expire;
    logic [CNT_BITS-1:0]   real_det;
    logic [RATIO_BITS-1:0] near_low;
    logic [RATIO_BITS-1:0] near_high;
    logic [RATIO_BITS-1:0] near_move;
    logic [RATIO_BITS-1:0] far_low;
    logic [RATIO_BITS-1:0] far_high;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input item
    logic clr_scan;    // reset slot pointer and flags
    logic step;        // advance slot pointer
    logic upd_def;     // scan pass: 1 definite, 0 potential
    logic do_update;   // apply match update at current slot
    logic do_alloc;    // allocate free slot
    logic do_promote;  // promote current slot if eligible
    logic do_purge;    // purge current slot if stale
    logic do_pick;     // consider slot for report minimum
    logic do_report;   // mark chosen and load report result
    logic do_single;   // load single result of a detection
    logic do_none;     // load no-faces result
    logic frame_adv;   // advance frame counter
  } dtt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_eof;
    logic slot_last;
    logic found_def;
    logic found_pot;
    logic has_free;
    logic have_best;
    logic rep_full;
    logic rep_final;   // chosen report is the last one of the frame
  } dtt_stat_t;

endpackage

@@ hdl/dtt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_in_if / dtt_out_if
// Request and result channels of the detection track table.
// ----------------------------------------------------------------------------
interface dtt_in_if #(parameter int COORD_BITS = dtt_pkg::COORD_BITS_DEF);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [COORD_BITS-1:0] x;
  logic [COORD_BITS-1:0] y;
  logic [COORD_BITS-1:0] width;
  logic [COORD_BITS-1:0] height;
  modport source (output valid, kind, x, y, width, height, input ready);
  modport sink (input valid, kind, x, y, width, height, output ready);
endinterface

interface dtt_out_if #(parameter int COORD_BITS = dtt_pkg::COORD_BITS_DEF);
  logic                                valid;
  logic                                ready;
  logic [dtt_pkg::VERDICT_BITS-1:0]    verdict;
  logic [dtt_pkg::ID_BITS-1:0]         face_id;
  logic [dtt_pkg::MASK_BITS-1:0]       mask_index;
  logic [COORD_BITS-1:0]               rep_x;
  logic [COORD_BITS-1:0]               rep_y;
  logic [COORD_BITS-1:0]               rep_width;
  logic [COORD_BITS-1:0]               rep_height;
  logic                                last;
  modport source (output valid, verdict, face_id, mask_index, rep_x, rep_y,
                  rep_width, rep_height, last, input ready);
  modport sink (input valid, verdict, face_id, mask_index, rep_x, rep_y,
                rep_width, rep_height, last, output ready);
endinterface

@@ hdl/detection_track_table.sv @@
`timescale 1ns / 1ps
// A detection runs a definite pass and then a potential pass over the slots (one slot
//   compared per cycle in each pass; the potential pass is skipped on a definite match).
// End of frame: a promote pass and a purge pass over the slots, then a search
//   over the slots for the next entry to report, before each reported entry.
// One item is processed at a time. Synchronous reset empties the table.
// ----------------------------------------------------------------------------
// detection_track_table
// Track table for detection rectangles with aging, promotion and reports.
// ----------------------------------------------------------------------------
module detection_track_table #(
  parameter int TABLE_DEPTH = dtt_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_BITS  = dtt_pkg::COORD_BITS_DEF,
  parameter int NUM_MASKS   = dtt_pkg::NUM_MASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  dtt_in_if.sink                        in_ch,
  dtt_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtt_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  dtt_pkg::cfg_t      cfg;
  dtt_pkg::dtt_cmd_t  cmd;
  dtt_pkg::dtt_stat_t stat;

  dtt_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  dtt_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH), .COORD_BITS(COORD_BITS), .NUM_MASKS(NUM_MASKS)
  ) u_dp (
    .clk, .rst, .cfg, .cmd, .stat,
    .in_kind(in_ch.kind), .in_x(in_ch.x), .in_y(in_ch.y),
    .in_w(in_ch.width), .in_h(in_ch.height),
    .res_verdict(out_ch.verdict), .res_id(out_ch.face_id),
    .res_mask(out_ch.mask_index), .res_x(out_ch.rep_x), .res_y(out_ch.rep_y),
    .res_w(out_ch.rep_width), .res_h(out_ch.rep_height)
  );

  dtt_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last),
    .cmd, .stat
  );

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while a result is pending");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("block busy after final result");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.do_alloc, cmd.do_single, cmd.do_report, cmd.do_none}) <= 1)
    else $error("conflicting result loads");
`endif

endmodule

@@ hdl/dtt_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_regs
// APB register file holding the matching and aging thresholds.
// ----------------------------------------------------------------------------
module dtt_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtt_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output dtt_pkg::cfg_t                 cfg
);

  logic [2:0] idx;
  logic       hit;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign hit    = (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.recent    <= 8'd5;
      cfg.expire    <= 8'd20;
      cfg.real_det  <= 8'd8;
      cfg.near_low  <= 16'd230;
      cfg.near_high <= 16'd284;
      cfg.near_move <= 16'd192;
      cfg.far_low   <= 16'd179;
      cfg.far_high  <= 16'd366;
    end else if (psel && penable && pwrite && hit) begin
      case (int'(idx))
        dtt_pkg::REG_RECENT:    cfg.recent    <= pwdata[7:0];
        dtt_pkg::REG_EXPIRE:    cfg.expire    <= pwdata[7:0];
        dtt_pkg::REG_REAL:      cfg.real_det  <= pwdata[7:0];
        dtt_pkg::REG_NEAR_LOW:  cfg.near_low  <= pwdata[15:0];
        dtt_pkg::REG_NEAR_HIGH: cfg.near_high <= pwdata[15:0];
        dtt_pkg::REG_NEAR_MOVE: cfg.near_move <= pwdata[15:0];
        dtt_pkg::REG_FAR_LOW:   cfg.far_low   <= pwdata[15:0];
        dtt_pkg::REG_FAR_HIGH:  cfg.far_high  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      case (int'(idx))
        dtt_pkg::REG_RECENT:    prdata = {24'd0, cfg.recent};
        dtt_pkg::REG_EXPIRE:    prdata = {24'd0, cfg.expire};
        dtt_pkg::REG_REAL:      prdata = {24'd0, cfg.real_det};
        dtt_pkg::REG_NEAR_LOW:  prdata = {16'd0, cfg.near_low};
        dtt_pkg::REG_NEAR_HIGH: prdata = {16'd0, cfg.near_high};
        dtt_pkg::REG_NEAR_MOVE: prdata = {16'd0, cfg.near_move};
        dtt_pkg::REG_FAR_LOW:   prdata = {16'd0, cfg.far_low};
        dtt_pkg::REG_FAR_HIGH:  prdata = {16'd0, cfg.far_high};
        default:                prdata = '0;
      endcase
    end
  end

endmodule

@@ hdl/dtt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_datapath
// Entry table, slot scanner, match compare unit and result register.
// ----------------------------------------------------------------------------
module dtt_datapath #(
  parameter int TABLE_DEPTH = dtt_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_BITS  = dtt_pkg::COORD_BITS_DEF,
  parameter int NUM_MASKS   = dtt_pkg::NUM_MASKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dtt_pkg::cfg_t                    cfg,
  input  dtt_pkg::dtt_cmd_t                cmd,
  output dtt_pkg::dtt_stat_t               stat,
  input  logic                             in_kind,
  input  logic [COORD_BITS-1:0]            in_x,
  input  logic [COORD_BITS-1:0]            in_y,
  input  logic [COORD_BITS-1:0]            in_w,
  input  logic [COORD_BITS-1:0]            in_h,
  output logic [dtt_pkg::VERDICT_BITS-1:0] res_verdict,
  output logic [dtt_pkg::ID_BITS-1:0]      res_id,
  output logic [dtt_pkg::MASK_BITS-1:0]    res_mask,
  output logic [COORD_BITS-1:0]            res_x,
  output logic [COORD_BITS-1:0]            res_y,
  output logic [COORD_BITS-1:0]            res_w,
  output logic [COORD_BITS-1:0]            res_h
);

  localparam int SB = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PB = COORD_BITS + 16;
  localparam int FB = dtt_pkg::FRAME_BITS;
  localparam int MB = dtt_pkg::MASK_BITS;
  localparam int RB = dtt_pkg::CNT_BITS;

  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] definite;
  logic [TABLE_DEPTH-1:0] done;
  logic [COORD_BITS-1:0]  e_x [TABLE_DEPTH];
  logic [COORD_BITS-1:0]  e_y [TABLE_DEPTH];
  logic [COORD_BITS-1:0]  e_w [TABLE_DEPTH];
  logic [COORD_BITS-1:0]  e_h [TABLE_DEPTH];
  logic [FB-1:0]          e_frame [TABLE_DEPTH];
  logic [RB-1:0]          e_hits [TABLE_DEPTH];
  logic [15:0]            e_id [TABLE_DEPTH];
  logic [MB-1:0]          e_mask [TABLE_DEPTH];
  logic [15:0]            e_order [TABLE_DEPTH];

  logic                  d_kind;
  logic [COORD_BITS-1:0] d_x, d_y, d_w, d_h;
  logic [FB-1:0]         frame_count;
  logic [15:0]           next_id;
  logic [MB-1:0]         mask_counter;
  logic [15:0]           promote_counter;

  logic [SB-1:0] slot;
  logic          found_def, found_pot, have_best, have_free, more;
  logic [SB-1:0] first_slot, best_slot, free_slot;
  logic [15:0]   best_age;
  logic [4:0]    rep_count;

  // current-slot compare
  logic [COORD_BITS-1:0] l_x, l_y, l_w, l_h;
  logic [FB-1:0]         gap;
  logic                  near;
  logic [15:0]           lo, hi, mv;
  logic [PB-1:0]         sw, sh, lo_w, hi_w, lo_h, hi_h, mv_w, mv_h, dx, dy;
  logic                  match;
  logic [15:0]           age;
  logic [MB-1:0]         mask_next;

  assign l_x  = e_x[slot];
  assign l_y  = e_y[slot];
  assign l_w  = e_w[slot];
  assign l_h  = e_h[slot];
  assign gap  = frame_count - e_frame[slot];
  assign near = (gap <= FB'(cfg.recent));
  assign lo   = near ? cfg.near_low  : cfg.far_low;
  assign hi   = near ? cfg.near_high : cfg.far_high;
  assign mv   = near ? cfg.near_move : dtt_pkg::FAR_MOVE;
  assign sw   = {8'd0, d_w, 8'd0};
  assign sh   = {8'd0, d_h, 8'd0};
  assign lo_w = PB'(lo) * PB'(l_w);
  assign hi_w = PB'(hi) * PB'(l_w);
  assign lo_h = PB'(lo) * PB'(l_h);
  assign hi_h = PB'(hi) * PB'(l_h);
  assign mv_w = PB'(mv) * PB'(l_w);
  assign mv_h = PB'(mv) * PB'(l_h);
  assign dx   = {8'd0, ((d_x > l_x) ? d_x - l_x : l_x - d_x), 8'd0};
  assign dy   = {8'd0, ((d_y > l_y) ? d_y - l_y : l_y - d_y), 8'd0};
  assign match = !(sw < lo_w) && !(sw > hi_w) && !(sh < lo_h) && !(sh > hi_h)
                 && !(dx > mv_w) && !(dy > mv_h);
  assign age  = promote_counter - e_order[slot];
  assign mask_next = (32'(mask_counter) + 1 >= NUM_MASKS) ? '0 : mask_counter + 1'b1;

  assign stat.is_eof    = d_kind;
  assign stat.slot_last = (32'(slot) == TABLE_DEPTH - 1);
  assign stat.found_def = found_def;
  assign stat.found_pot = found_pot;
  assign stat.has_free  = have_free;
  assign stat.have_best = have_best;
  assign stat.rep_full  = (32'(rep_count) == dtt_pkg::MAX_RESULTS);
  // no second candidate seen in the pick scan, or this report reaches the report limit
  assign stat.rep_final = !more || (32'(rep_count) == dtt_pkg::MAX_RESULTS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= '0;
      definite        <= '0;
      done            <= '0;
      frame_count     <= '0;
      next_id         <= '0;
      mask_counter    <= '0;
      promote_counter <= '0;
      slot            <= '0;
      found_def       <= 1'b0;
      found_pot       <= 1'b0;
      have_best       <= 1'b0;
      have_free       <= 1'b0;
      more            <= 1'b0;
      rep_count       <= '0;
      d_kind          <= 1'b0;
    end else begin
      if (cmd.load) begin
        d_kind <= in_kind;
        d_x    <= in_x;
        d_y    <= in_y;
        d_w    <= in_w;
        d_h    <= in_h;
      end
      if (cmd.clr_scan) begin
        slot      <= '0;
        have_best <= 1'b0;
        more      <= 1'b0;
        if (cmd.load) begin
          found_def <= 1'b0;
          found_pot <= 1'b0;
          have_free <= 1'b0;
          done      <= '0;
          rep_count <= '0;
        end
      end else if (cmd.step) begin
        slot <= (32'(slot) == TABLE_DEPTH - 1) ? '0 : slot + 1'b1;
      end
      if (cmd.do_update && valid[slot] && (definite[slot] == cmd.upd_def) && match) begin
        e_x[slot]     <= d_x;
        e_y[slot]     <= d_y;
        e_w[slot]     <= d_w;
        e_h[slot]     <= d_h;
        e_frame[slot] <= frame_count;
        if (e_hits[slot] != '1) e_hits[slot] <= e_hits[slot] + 1'b1;
        if (!(cmd.upd_def ? found_def : found_pot)) first_slot <= slot;
        if (cmd.upd_def) found_def <= 1'b1;
        else found_pot <= 1'b1;
      end
      // free-slot search rides along the definite pass
      if (cmd.do_update && cmd.upd_def && !valid[slot] && !have_free) begin
        have_free <= 1'b1;
        free_slot <= slot;
      end
      if (cmd.do_alloc) begin
        valid[free_slot]    <= 1'b1;
        definite[free_slot] <= 1'b0;
        e_x[free_slot]      <= d_x;
        e_y[free_slot]      <= d_y;
        e_w[free_slot]      <= d_w;
        e_h[free_slot]      <= d_h;
        e_frame[free_slot]  <= frame_count;
        e_hits[free_slot]   <= RB'(1);
        e_id[free_slot]     <= next_id + 1'b1;
        e_mask[free_slot]   <= mask_next;
        next_id             <= next_id + 1'b1;
        mask_counter        <= mask_next;
        res_verdict         <= dtt_pkg::V_ADDED;
        res_id              <= next_id + 1'b1;
        res_mask            <= mask_next;
        res_x <= d_x; res_y <= d_y; res_w <= d_w; res_h <= d_h;
      end
      if (cmd.do_single) begin
        if (found_def || found_pot) begin
          res_verdict <= found_def ? dtt_pkg::V_DEFINITE : dtt_pkg::V_POTENTIAL;
          res_id      <= e_id[first_slot];
          res_mask    <= e_mask[first_slot];
          res_x <= d_x; res_y <= d_y; res_w <= d_w; res_h <= d_h;
        end else begin
          res_verdict <= dtt_pkg::V_FULL;
          res_id <= '0; res_mask <= '0;
          res_x <= '0; res_y <= '0; res_w <= '0; res_h <= '0;
        end
      end
      if (cmd.do_promote && valid[slot] && !definite[slot]
          && (e_hits[slot] > cfg.real_det)) begin
        definite[slot] <= 1'b1;
        e_order[slot]  <= promote_counter;
        promote_counter <= promote_counter + 1'b1;
      end
      if (cmd.do_purge && valid[slot] && (gap > FB'(cfg.expire))) begin
        valid[slot]    <= 1'b0;
        definite[slot] <= 1'b0;
      end
      if (cmd.do_pick && valid[slot] && definite[slot] && !done[slot]) begin
        if (have_best) more <= 1'b1;
        if (!have_best || age > best_age) begin
          have_best <= 1'b1;
          best_slot <= slot;
          best_age  <= age;
        end
      end
      if (cmd.do_report) begin
        done[best_slot] <= 1'b1;
        rep_count       <= rep_count + 1'b1;
        res_verdict     <= dtt_pkg::V_REPORT;
        res_id          <= e_id[best_slot];
        res_mask        <= e_mask[best_slot];
        res_x <= e_x[best_slot]; res_y <= e_y[best_slot];
        res_w <= e_w[best_slot]; res_h <= e_h[best_slot];
      end
      if (cmd.do_none) begin
        res_verdict <= dtt_pkg::V_NONE;
        res_id <= '0; res_mask <= '0;
        res_x <= '0; res_y <= '0; res_w <= '0; res_h <= '0;
      end
      if (cmd.frame_adv) frame_count <= frame_count + 1'b1;
    end
  end

endmodule

@@ hdl/dtt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_ctrl
// Sequencer: match passes, allocation, promote/purge, ordered reporting.
// ----------------------------------------------------------------------------
module dtt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_last,
  output dtt_pkg::dtt_cmd_t  cmd,
  input  dtt_pkg::dtt_stat_t stat
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEF    = 4'd1;
  localparam logic [3:0] S_POT    = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_PROM   = 4'd4;
  localparam logic [3:0] S_PURGE  = 4'd5;
  localparam logic [3:0] S_PICK   = 4'd6;
  localparam logic [3:0] S_REP    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state, state_next;
  logic       last_flag, last_flag_next;
  logic       eof_out, eof_out_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_last  = last_flag;

  always_comb begin
    state_next     = state;
    last_flag_next = last_flag;
    eof_out_next   = eof_out;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.clr_scan = 1'b1;
          state_next   = S_DEF;
        end
      end
      S_DEF: begin
        if (stat.is_eof) begin
          state_next = S_PROM;
        end else begin
          cmd.do_update = 1'b1;
          cmd.upd_def   = 1'b1;
          cmd.step      = 1'b1;
          if (stat.slot_last) state_next = S_POT;
        end
      end
      S_POT: begin
        if (stat.found_def) begin
          state_next = S_DECIDE;
        end else begin
          cmd.do_update = 1'b1;
          cmd.step      = 1'b1;
          if (stat.slot_last) state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.found_def && !stat.found_pot && stat.has_free) cmd.do_alloc = 1'b1;
        else cmd.do_single = 1'b1;
        last_flag_next = 1'b1;
        eof_out_next   = 1'b0;
        state_next     = S_OUT;
      end
      S_PROM: begin
        cmd.do_promote = 1'b1;
        cmd.step       = 1'b1;
        if (stat.slot_last) state_next = S_PURGE;
      end
      S_PURGE: begin
        cmd.do_purge = 1'b1;
        cmd.step     = 1'b1;
        if (stat.slot_last) begin
          cmd.step     = 1'b0;
          cmd.clr_scan = 1'b1;
          state_next   = S_PICK;
        end
      end
      S_PICK: begin
        cmd.do_pick = 1'b1;
        cmd.step    = 1'b1;
        if (stat.slot_last) state_next = S_REP;
      end
      S_REP: begin
        eof_out_next = 1'b1;
        if (stat.have_best && !stat.rep_full) begin
          // last report closes the item and the frame
          cmd.do_report  = 1'b1;
          last_flag_next = stat.rep_final;
          cmd.frame_adv  = stat.rep_final;
          state_next     = S_OUT;
        end else begin
          cmd.do_none    = 1'b1;
          last_flag_next = 1'b1;
          cmd.frame_adv  = 1'b1;
          state_next     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (eof_out && !last_flag) begin
            cmd.clr_scan = 1'b1;
            state_next   = S_PICK;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_flag <= 1'b1;
      eof_out   <= 1'b0;
    end else begin
      state     <= state_next;
      last_flag <= last_flag_next;
      eof_out   <= eof_out_next;
    end
  end

endmodule

@@ bench/detection_track_table_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_track_table_test
// Drives detections and end-of-frame requests through the track table under
// three idling settings and four register settings, and checks every
// result request, field by field, against a built-in model of the table.
// ----------------------------------------------------------------------------
module detection_track_table_test;

  localparam int DEPTH = 16;
  localparam int NMASK = 3;
  localparam int AB = dtt_pkg::ADDR_BITS;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] face_id;
    logic [2:0]  mask_index;
    logic [11:0] rx;
    logic [11:0] ry;
    logic [11:0] rw;
    logic [11:0] rh;
    logic        last;
  } face_res_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
  } det_req_t;

  typedef struct {
    det_req_t  req;
    logic      typed;
    face_res_t res;
  } table_row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [AB-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  dtt_in_if  in_ch ();
  dtt_out_if out_ch ();

  detection_track_table uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // model state
  logic [7:0]  m_recent, m_expire, m_real;
  logic [15:0] m_nlow, m_nhigh, m_nmove, m_flow, m_fhigh;
  logic        t_valid [DEPTH];
  logic        t_def [DEPTH];
  logic [11:0] t_rect [DEPTH][4];
  logic [15:0] t_seen [DEPTH];
  logic [7:0]  t_hits [DEPTH];
  logic [15:0] t_id [DEPTH];
  logic [2:0]  t_mask [DEPTH];
  logic [15:0] t_order [DEPTH];
  logic [15:0] frame_no, id_next, promo_next;
  logic [2:0]  mask_next;

  face_res_t expected_faces[$];
  int errors = 0;
  int checked = 0;
  int fed = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic size_fits(logic [11:0] d, logic [11:0] l, logic [15:0] lo,
                                     logic [15:0] hi);
    logic [31:0] s;
    s = {12'd0, d, 8'd0};
    return !(s < 32'(lo) * 32'(l) || s > 32'(hi) * 32'(l));
  endfunction

  function automatic logic rect_matches(int e, det_req_t r);
    logic [15:0] gap, lo, hi, mv;
    logic [11:0] dx, dy;
    gap = frame_no - t_seen[e];
    if (gap <= 16'(m_recent)) begin
      lo = m_nlow; hi = m_nhigh; mv = m_nmove;
    end else begin
      lo = m_flow; hi = m_fhigh; mv = dtt_pkg::FAR_MOVE;
    end
    if (!size_fits(r.w, t_rect[e][2], lo, hi) || !size_fits(r.h, t_rect[e][3], lo, hi))
      return 0;
    dx = r.x > t_rect[e][0] ? r.x - t_rect[e][0] : t_rect[e][0] - r.x;
    dy = r.y > t_rect[e][1] ? r.y - t_rect[e][1] : t_rect[e][1] - r.y;
    if ({12'd0, dx, 8'd0} > 32'(mv) * 32'(t_rect[e][2])) return 0;
    if ({12'd0, dy, 8'd0} > 32'(mv) * 32'(t_rect[e][3])) return 0;
    return 1;
  endfunction

  function automatic int refresh_tracks(logic definite, det_req_t r);
    int first;
    first = -1;
    for (int e = 0; e < DEPTH; e++) begin
      if (t_valid[e] && t_def[e] == definite && rect_matches(e, r)) begin
        t_rect[e] = '{r.x, r.y, r.w, r.h};
        if (t_hits[e] != 8'hFF) t_hits[e]++;
        t_seen[e] = frame_no;
        if (first < 0) first = e;
      end
    end
    return first;
  endfunction

  // computes the results of one request and queues them
  task automatic track_request(det_req_t r);
    int e, n, best;
    logic [15:0] best_age, age;
    logic done [DEPTH];
    face_res_t f;
    if (!r.kind) begin
      e = refresh_tracks(1, r);
      if (e >= 0) begin
        expected_faces.push_back('{dtt_pkg::V_DEFINITE, t_id[e], t_mask[e],
                                   r.x, r.y, r.w, r.h, 1});
        return;
      end
      e = refresh_tracks(0, r);
      if (e >= 0) begin
        expected_faces.push_back('{dtt_pkg::V_POTENTIAL, t_id[e], t_mask[e],
                                   r.x, r.y, r.w, r.h, 1});
        return;
      end
      for (e = 0; e < DEPTH; e++) if (!t_valid[e]) break;
      if (e >= DEPTH) begin
        expected_faces.push_back('{dtt_pkg::V_FULL, 0, 0, 0, 0, 0, 0, 1});
        return;
      end
      id_next++;
      mask_next = (32'(mask_next) + 1 >= NMASK) ? 3'd0 : mask_next + 3'd1;
      t_valid[e] = 1; t_def[e] = 0;
      t_rect[e] = '{r.x, r.y, r.w, r.h};
      t_seen[e] = frame_no; t_hits[e] = 1;
      t_id[e] = id_next; t_mask[e] = mask_next;
      expected_faces.push_back('{dtt_pkg::V_ADDED, id_next, mask_next,
                                 r.x, r.y, r.w, r.h, 1});
      return;
    end
    for (e = 0; e < DEPTH; e++)
      if (t_valid[e] && !t_def[e] && t_hits[e] > m_real) begin
        t_def[e] = 1; t_order[e] = promo_next; promo_next++;
      end
    for (e = 0; e < DEPTH; e++)
      if (t_valid[e] && 16'(frame_no - t_seen[e]) > 16'(m_expire)) begin
        t_valid[e] = 0; t_def[e] = 0;
      end
    for (e = 0; e < DEPTH; e++) done[e] = 0;
    n = 0;
    while (n < dtt_pkg::MAX_RESULTS) begin
      best = -1; best_age = 0;
      for (e = 0; e < DEPTH; e++) begin
        if (!t_valid[e] || !t_def[e] || done[e]) continue;
        age = promo_next - t_order[e];
        if (best < 0 || age > best_age) begin
          best = e; best_age = age;
        end
      end
      if (best < 0) break;
      done[best] = 1;
      expected_faces.push_back('{dtt_pkg::V_REPORT, t_id[best], t_mask[best],
                                 t_rect[best][0], t_rect[best][1], t_rect[best][2],
                                 t_rect[best][3], 0});
      n++;
    end
    if (n == 0) expected_faces.push_back('{dtt_pkg::V_NONE, 0, 0, 0, 0, 0, 0, 1});
    else begin
      f = expected_faces.pop_back();
      f.last = 1;
      expected_faces.push_back(f);
    end
    frame_no++;
  endtask

  // result side: random stall, compare on accept
  always @(posedge clk) begin
    face_res_t got, want;
    if (rst) out_ch.ready <= 0;
    else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.verdict, out_ch.face_id, out_ch.mask_index, out_ch.rep_x,
                out_ch.rep_y, out_ch.rep_width, out_ch.rep_height, out_ch.last};
        if (expected_faces.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_faces.pop_front();
          checked++;
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic write_reg(int idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= AB'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      dtt_pkg::REG_RECENT:    m_recent = val[7:0];
      dtt_pkg::REG_EXPIRE:    m_expire = val[7:0];
      dtt_pkg::REG_REAL:      m_real = val[7:0];
      dtt_pkg::REG_NEAR_LOW:  m_nlow = val[15:0];
      dtt_pkg::REG_NEAR_HIGH: m_nhigh = val[15:0];
      dtt_pkg::REG_NEAR_MOVE: m_nmove = val[15:0];
      dtt_pkg::REG_FAR_LOW:   m_flow = val[15:0];
      dtt_pkg::REG_FAR_HIGH:  m_fhigh = val[15:0];
      default: ;
    endcase
  endtask

  task automatic send_request(det_req_t r);
    do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    in_ch.valid <= 1;
    {in_ch.kind, in_ch.x, in_ch.y, in_ch.width, in_ch.height} <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_request(r);
    fed++;
    in_ch.valid <= 0;
  endtask

  task automatic drain();
    while (expected_faces.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // random requests, mostly tracks that move a little around four base rectangles
  task automatic random_burst(int count);
    det_req_t r;
    logic [11:0] bx [4], by [4], bw [4];
    for (int k = 0; k < 4; k++) begin
      bx[k] = 12'($urandom_range(3000)); by[k] = 12'($urandom_range(3000));
      bw[k] = 12'($urandom_range(20, 400));
    end
    for (int i = 0; i < count; i++) begin
      int k, pick;
      k = $urandom_range(3);
      pick = $urandom_range(99);
      if (pick < 15) r = '{1, 0, 0, 0, 0};
      else if (pick < 25) r = '{0, 12'($urandom), 12'($urandom), 12'($urandom),
                                 12'($urandom)};
      else if (pick < 28) r = '{1, 12'($urandom), 12'($urandom), 12'($urandom),
                                 12'($urandom)};
      else r = '{0, 12'(bx[k] + $urandom_range(10)), 12'(by[k] + $urandom_range(10)),
                 12'(bw[k] + $urandom_range(6)), 12'(bw[k] + $urandom_range(6))};
      send_request(r);
    end
  endtask

  table_row_t plan[$];

  initial begin
    det_req_t r;
    face_res_t got;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_ch.valid = 0; in_ch.kind = 0; in_ch.x = 0; in_ch.y = 0;
    in_ch.width = 1; in_ch.height = 1;
    m_recent = 5; m_expire = 20; m_real = 8;
    m_nlow = 230; m_nhigh = 284; m_nmove = 192; m_flow = 179; m_fhigh = 366;
    for (int e = 0; e < DEPTH; e++) begin
      t_valid[e] = 0; t_def[e] = 0; t_hits[e] = 0; t_seen[e] = 0;
      t_id[e] = 0; t_mask[e] = 0; t_order[e] = 0;
      for (int j = 0; j < 4; j++) t_rect[e][j] = 0;
    end
    frame_no = 0; id_next = 0; promo_next = 0; mask_next = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table
    plan.push_back('{'{1, 0, 0, 0, 0}, 1, '{dtt_pkg::V_NONE, 0, 0, 0, 0, 0, 0, 1}});
    plan.push_back('{'{0, 100, 100, 50, 50}, 1,
                     '{dtt_pkg::V_ADDED, 1, 1, 100, 100, 50, 50, 1}});
    plan.push_back('{'{0, 105, 102, 52, 49}, 1,
                     '{dtt_pkg::V_POTENTIAL, 1, 1, 105, 102, 52, 49, 1}});
    plan.push_back('{'{0, 4095, 4095, 4095, 4095}, 1,
                     '{dtt_pkg::V_ADDED, 2, 2, 4095, 4095, 4095, 4095, 1}});
    plan.push_back('{'{0, 0, 0, 1, 1}, 1, '{dtt_pkg::V_ADDED, 3, 0, 0, 0, 1, 1, 1}});
    plan.push_back('{'{0, 0, 0, 0, 0}, 0, '0});
    for (int i = 0; i < 9; i++) plan.push_back('{'{0, 105, 102, 52, 49}, 0, '0});
    plan.push_back('{'{1, 0, 0, 0, 0}, 0, '0});
    plan.push_back('{'{0, 106, 101, 52, 50}, 0, '0});
    plan.push_back('{'{1, 4095, 4095, 4095, 4095}, 0, '0});
    foreach (plan[i]) begin
      send_request(plan[i].req);
      if (plan[i].typed) begin
        got = expected_faces[expected_faces.size() - 1];
        if (got !== plan[i].res) begin
          errors++;
          if (errors <= 10) $display("row %0d: table %p, model %p", i, plan[i].res, got);
        end
      end
    end
    // fill the table to reach the full case
    for (int i = 0; i < 16; i++) send_request('{0, 12'(i * 250), 3000, 10, 10});
    drain();

    src_idle_pct = 22; snk_idle_pct = 49;
    write_reg(dtt_pkg::REG_RECENT, 0); write_reg(dtt_pkg::REG_EXPIRE, 0);
    write_reg(dtt_pkg::REG_REAL, 0);
    write_reg(dtt_pkg::REG_NEAR_LOW, 0); write_reg(dtt_pkg::REG_NEAR_HIGH, 65535);
    write_reg(dtt_pkg::REG_NEAR_MOVE, 65535); write_reg(dtt_pkg::REG_FAR_LOW, 0);
    write_reg(dtt_pkg::REG_FAR_HIGH, 65535);
    random_burst(80);
    drain();

    src_idle_pct = 49; snk_idle_pct = 22;
    write_reg(dtt_pkg::REG_RECENT, 255); write_reg(dtt_pkg::REG_EXPIRE, 255);
    write_reg(dtt_pkg::REG_REAL, 255);
    write_reg(dtt_pkg::REG_NEAR_LOW, 65535); write_reg(dtt_pkg::REG_NEAR_HIGH, 0);
    write_reg(dtt_pkg::REG_NEAR_MOVE, 0); write_reg(dtt_pkg::REG_FAR_LOW, 65535);
    write_reg(dtt_pkg::REG_FAR_HIGH, 0);
    random_burst(40);
    drain();
    write_reg(dtt_pkg::REG_RECENT, 3); write_reg(dtt_pkg::REG_EXPIRE, 12);
    write_reg(dtt_pkg::REG_REAL, 3);
    write_reg(dtt_pkg::REG_NEAR_LOW, 200); write_reg(dtt_pkg::REG_NEAR_HIGH, 300);
    write_reg(dtt_pkg::REG_NEAR_MOVE, 128); write_reg(dtt_pkg::REG_FAR_LOW, 150);
    write_reg(dtt_pkg::REG_FAR_HIGH, 400);
    random_burst(40);
    drain();

    src_idle_pct = 0; snk_idle_pct = 0;
    write_reg(dtt_pkg::REG_RECENT, 5); write_reg(dtt_pkg::REG_EXPIRE, 20);
    write_reg(dtt_pkg::REG_REAL, 8);
    write_reg(dtt_pkg::REG_NEAR_LOW, 230); write_reg(dtt_pkg::REG_NEAR_HIGH, 284);
    write_reg(dtt_pkg::REG_NEAR_MOVE, 192); write_reg(dtt_pkg::REG_FAR_LOW, 179);
    write_reg(dtt_pkg::REG_FAR_HIGH, 366);
    random_burst(60);
    drain();

    $display("%0d requests sent over 4 register settings and 3 idling phases", fed);
    $display("%0d results compared, %0d failures", checked, errors);
    if (errors == 0 && expected_faces.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/dtt_pkg.sv
hdl/dtt_if.sv
hdl/dtt_regs.sv
hdl/dtt_datapath.sv
hdl/dtt_ctrl.sv
hdl/detection_track_table.sv
bench/detection_track_table_test.sv
